### hw/rtl/rgb_to_yuv_pixel_converter_top_assert.svh
// assertion helpers for the pixel converter, sampled on clock, off in reset
`ifndef RGB_TO_YUV_PIXEL_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_YUV_PIXEL_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define RYUV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ryuv assertion failed");

// next-cycle implication
`define RYUV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ryuv assertion failed");

`endif

### hw/rtl/ryuv_pkg.sv
`default_nettype none

package ryuv_pkg;

   // csr register indexes
   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_LUMA_WEIGHTS = 2'd1,
      CSR_BLUE_WEIGHTS = 2'd2,
      CSR_RED_WEIGHTS  = 2'd3
   } csr_index_type;

   localparam int unsigned WEIGHT_W = 24;
   localparam int unsigned FORMAT_W = 2;

   // reset values of the registers
   localparam logic [FORMAT_W-1:0] FORMAT_RESET = 2'd0;
   localparam logic [WEIGHT_W-1:0] LUMA_RESET   = 24'h0D4121;
   localparam logic [WEIGHT_W-1:0] BLUE_RESET   = 24'h70B6DA;
   localparam logic [WEIGHT_W-1:0] RED_RESET    = 24'hEEA270;

   // scaling
   localparam int unsigned    LUMA_SHIFT    = 7;
   localparam int unsigned    CHROMA_SHIFT  = 8;
   localparam logic [15:0]    LUMA_OFFSET   = 16'd16;
   localparam logic [15:0]    CHROMA_OFFSET = 16'd128;

   typedef logic [7:0] chan_type;

   // signed-weight dot product over three channels, 16-bit wrap,
   // arithmetic shift, offset and saturation to a byte
   function automatic chan_type convert(input chan_type c0, input chan_type c1,
                                        input chan_type c2,
                                        input logic [WEIGHT_W-1:0] w,
                                        input logic is_luma);
      logic signed [15:0] p0;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] acc;
      logic signed [15:0] shf;
      logic [15:0]        sum;
      chan_type           res;
      p0  = signed'({8'd0, c0}) * 16'(signed'(w[7:0]));
      p1  = signed'({8'd0, c1}) * 16'(signed'(w[15:8]));
      p2  = signed'({8'd0, c2}) * 16'(signed'(w[23:16]));
      acc = p0 + p1 + p2;
      if (is_luma) begin
         shf = acc >>> LUMA_SHIFT;
         sum = 16'(shf) + LUMA_OFFSET;
      end else begin
         shf = acc >>> CHROMA_SHIFT;
         sum = 16'(shf) + CHROMA_OFFSET;
      end
      if (sum[15]) begin
         res = 8'd0;
      end else if (|sum[14:8]) begin
         res = 8'hFF;
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rgb_to_yuv_pixel_converter_top.sv
// channel  direction  beat handshake         payload
// req      in         req_valid, req_stall   req_pixel_word[31:0]
// rsp      out        rsp_valid, rsp_stall   rsp_luma, rsp_chroma_blue, rsp_chroma_red
// csr      in         csr_valid, csr_ready   csr_index[1:0], csr_wdata[23:0]
//
// one pixel per cycle sustained unless rsp stalls; each beat crosses both stages
// stage one holds the unpacked channels, stage two the saturated results; the
// nine 8x8 products and the three sums sit between them
// reset clears both stage valids and loads the default BT.601 weights
// a stalled rsp holds stage two; stage one keeps taking a beat while stage two
// is free, so req_stall rises only when both stages are full and rsp is stalled
`default_nettype none

`include "rgb_to_yuv_pixel_converter_top_assert.svh"

module rgb_to_yuv_pixel_converter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_pixel_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_luma,
   output logic [7:0]       rsp_chroma_blue,
   output logic [7:0]       rsp_chroma_red,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   logic [ryuv_pkg::FORMAT_W-1:0] format_ff;
   logic [ryuv_pkg::WEIGHT_W-1:0] luma_w_ff;
   logic [ryuv_pkg::WEIGHT_W-1:0] blue_w_ff;
   logic [ryuv_pkg::WEIGHT_W-1:0] red_w_ff;

   ryuv_pkg::chan_type ch0_in, ch1_in, ch2_in;
   ryuv_pkg::chan_type ch0_ff, ch1_ff, ch2_ff;
   logic               s1_valid_ff;
   logic               out_load;
   logic               s1_load;

   ryuv_pkg::chan_type luma_in, blue_in, red_in;
   ryuv_pkg::chan_type luma_ff, blue_ff, red_ff;
   logic               out_valid_ff;

   logic [4:0] r5;
   logic [5:0] g6;
   logic [4:0] b5;

   // csr writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= ryuv_pkg::FORMAT_RESET;
         luma_w_ff <= ryuv_pkg::LUMA_RESET;
         blue_w_ff <= ryuv_pkg::BLUE_RESET;
         red_w_ff  <= ryuv_pkg::RED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (ryuv_pkg::csr_index_type'(csr_index))
            ryuv_pkg::CSR_PIXEL_FORMAT: format_ff <= csr_wdata[ryuv_pkg::FORMAT_W-1:0];
            ryuv_pkg::CSR_LUMA_WEIGHTS: luma_w_ff <= csr_wdata;
            ryuv_pkg::CSR_BLUE_WEIGHTS: blue_w_ff <= csr_wdata;
            ryuv_pkg::CSR_RED_WEIGHTS:  red_w_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advance
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || out_load;
   assign req_stall = !s1_load;

   // unpack pixel into three 8-bit channels: rgb565 widened by replication, or raw bytes
   assign r5 = req_pixel_word[15:11];
   assign g6 = req_pixel_word[10:5];
   assign b5 = req_pixel_word[4:0];

   always_comb begin
      if (format_ff[1]) begin
         ch0_in = {r5, r5[4:2]};
         ch1_in = {g6, g6[5:4]};
         ch2_in = {b5, b5[4:2]};
      end else begin
         ch0_in = req_pixel_word[7:0];
         ch1_in = req_pixel_word[15:8];
         ch2_in = req_pixel_word[23:16];
      end
   end

   // stage one: channel register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_load && req_valid) begin
         ch0_ff <= ch0_in;
         ch1_ff <= ch1_in;
         ch2_ff <= ch2_in;
      end
   end

   // three dot products with scaling and saturation
   assign luma_in = ryuv_pkg::convert(ch0_ff, ch1_ff, ch2_ff, luma_w_ff, 1'b1);
   assign blue_in = ryuv_pkg::convert(ch0_ff, ch1_ff, ch2_ff, blue_w_ff, 1'b0);
   assign red_in  = ryuv_pkg::convert(ch0_ff, ch1_ff, ch2_ff, red_w_ff, 1'b0);

   // stage two: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (out_load && s1_valid_ff) begin
         luma_ff <= luma_in;
         blue_ff <= blue_in;
         red_ff  <= red_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_luma        = luma_ff;
   assign rsp_chroma_blue = blue_ff;
   assign rsp_chroma_red  = red_ff;

   // an accepted beat always lands in stage one
   `RYUV_ASSERT_NEXT(a_req_lands, req_valid && !req_stall, s1_valid_ff)
   // a full stage one moves to the output when it is free
   `RYUV_ASSERT_NEXT(a_s1_moves, s1_valid_ff && out_load, out_valid_ff)
   // a blocked stage one keeps its channels
   `RYUV_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !out_load,
                     s1_valid_ff && $stable(ch0_ff) && $stable(ch1_ff) && $stable(ch2_ff))
   // input stalls only when both stages are full
   `RYUV_ASSERT_NOW(a_stall_full, req_stall, s1_valid_ff && out_valid_ff && rsp_stall)

endmodule

`default_nettype wire
